>>> rtl/core/lfc_pkg.sv
package lfc_pkg;

   // role of a byte within the frame, also the tracker state
   typedef enum logic [2:0] {
      ROLE_CMD0   = 3'd0,
      ROLE_CMD1   = 3'd1,
      ROLE_LEN    = 3'd2,
      ROLE_DATA   = 3'd3,
      ROLE_SUM_HI = 3'd4,
      ROLE_SUM_LO = 3'd5
   } role_type;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned SumWidth  = 16;

   typedef logic [ByteWidth-1:0] byte_type;
   typedef logic [SumWidth-1:0]  sum_type;

   // one tagged result item
   typedef struct packed {
      byte_type byte_value;
      role_type byte_role;
      logic     frame_end;
      logic     checksum_ok;
   } rsp_type;

endpackage

>>> rtl/core/lfc_req_if.sv
interface lfc_req_if import lfc_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

>>> rtl/core/lfc_rsp_if.sv
interface lfc_rsp_if import lfc_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type byte_value;
   role_type byte_role;
   logic     frame_end;
   logic     checksum_ok;

   modport source (output valid, output byte_value, output byte_role,
                   output frame_end, output checksum_ok, input ready);
   modport sink (input valid, input byte_value, input byte_role,
                 input frame_end, input checksum_ok, output ready);
endinterface

>>> rtl/core/lfc_tracker.sv
module lfc_tracker import lfc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     step,
   input  byte_type rx_byte,
   output rsp_type  result
);

   role_type phase_ff, phase_in;
   byte_type left_ff, left_in;
   sum_type  sum_ff, sum_in;
   byte_type high_ff, high_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ROLE_CMD0;
         left_ff  <= '0;
         sum_ff   <= '0;
         high_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         sum_ff   <= sum_in;
         high_ff  <= high_in;
      end
   end

   always_comb begin
      phase_in           = phase_ff;
      left_in            = left_ff;
      sum_in             = sum_ff + sum_type'(rx_byte);
      high_in            = high_ff;
      result.byte_value  = rx_byte;
      result.byte_role   = ROLE_CMD0;
      result.frame_end   = 1'b0;
      result.checksum_ok = 1'b0;
      case (phase_ff)
         ROLE_CMD1: begin
            result.byte_role = ROLE_CMD1;
            phase_in         = ROLE_LEN;
         end
         ROLE_LEN: begin
            result.byte_role = ROLE_LEN;
            left_in          = rx_byte;
            phase_in         = (rx_byte == '0) ? ROLE_SUM_HI : ROLE_DATA;
         end
         ROLE_DATA: begin
            result.byte_role = ROLE_DATA;
            left_in          = left_ff - byte_type'(1);
            if (left_ff == byte_type'(1)) begin
               phase_in = ROLE_SUM_HI;
            end
         end
         ROLE_SUM_HI: begin
            result.byte_role = ROLE_SUM_HI;
            sum_in           = sum_ff;
            high_in          = rx_byte;
            phase_in         = ROLE_SUM_LO;
         end
         ROLE_SUM_LO: begin
            result.byte_role   = ROLE_SUM_LO;
            result.frame_end   = 1'b1;
            result.checksum_ok = ({high_ff, rx_byte} == sum_ff);
            sum_in             = '0;
            left_in            = '0;
            phase_in           = ROLE_CMD0;
         end
         default: begin
            // first command byte, also the unreachable codes
            result.byte_role = ROLE_CMD0;
            sum_in           = sum_type'(rx_byte);
            left_in          = '0;
            phase_in         = ROLE_CMD1;
         end
      endcase
   end

endmodule

>>> rtl/core/length_prefixed_frame_checker_unit.sv
// Frame checker for a received byte stream: two command bytes, a length byte L, L payload
// bytes and a big-endian 16-bit checksum equal to the wrapping sum of the command, length
// and payload bytes. Every accepted item gives exactly one result item carrying the byte,
// its role (0 first command, 1 second command, 2 length, 3 payload, 4 checksum high,
// 5 checksum low), frame_end on the checksum low byte and checksum_ok there when the sums
// agree (0 on every other byte). There is no resynchronisation: a lost or extra byte shifts
// the roles of all that follow. Throughput is one item per clock while the result is not
// stalled; an accepted item goes through an input register and then a result register, with
// the role tracker in between. While a result waits the input register still takes one more
// item, after that the input stalls until the result is taken.
module length_prefixed_frame_checker_unit import lfc_pkg::*; (
   input logic          clock,
   input logic          reset,
   lfc_req_if.sink      req_chan,
   lfc_rsp_if.source    rsp_chan
);

   // input register
   logic     in_valid_ff, in_valid_in;
   byte_type in_byte_ff;

   // result register
   logic     out_valid_ff, out_valid_in;
   rsp_type  out_ff;

   rsp_type  result;
   logic     advance;
   logic     step;

   // result register free or being emptied this cycle
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign step           = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.rx_byte;
      end
      if (step) begin
         out_ff <= result;
      end
   end

   // frame state and per-byte tagging
   lfc_tracker u_tracker (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.byte_value  = out_ff.byte_value;
   assign rsp_chan.byte_role   = out_ff.byte_role;
   assign rsp_chan.frame_end   = out_ff.frame_end;
   assign rsp_chan.checksum_ok = out_ff.checksum_ok;

   // frame end marks exactly the checksum low byte
   a_end_on_sum_lo : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.frame_end == (rsp_chan.byte_role == ROLE_SUM_LO)))
      else $error("frame_end does not match checksum low role");

   // a match is only reported at frame end
   a_ok_only_at_end : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.checksum_ok) |-> rsp_chan.frame_end)
      else $error("checksum_ok outside frame end");

   // a buffered input item never gets dropped while the output stalls
   a_input_held : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_chan.ready) |=> (in_valid_ff && out_valid_ff))
      else $error("item lost during output stall");

endmodule

>>> dv/tb.sv
module tb;
   import lfc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // how the payload of a generated frame is filled
   typedef enum int {
      FILL_RANDOM,
      FILL_ONES,
      FILL_ZEROS
   } payload_fill_type;

   localparam int          NoDrop      = -1;
   localparam int unsigned StreamItems = 650;
   localparam int unsigned MaxWait     = 11;
   localparam int unsigned MaxReports  = 10;
   localparam int unsigned DrainCycles = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lfc_req_if req_if ();
   lfc_rsp_if rsp_if ();

   length_prefixed_frame_checker_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #6 clock = ~clock;

   // bytes still to be offered, filled once before reset is released
   byte_type rx_stream[$];
   // tagged bytes the block owes us, oldest first
   rsp_type  expected_tags[$];

   // our own copy of the frame tracker
   role_type    phase_q    = ROLE_CMD0;
   byte_type    left_q     = '0;
   sum_type     sum_q      = '0;
   byte_type    sum_high_q = '0;

   // framing position as the stream generator sees it, used to realign after noise
   role_type    gen_role;
   int unsigned gen_left;

   int unsigned fail_count;
   int unsigned items_in;
   int unsigned results_seen;
   int unsigned frames_good;
   int unsigned frames_bad;

   // work out the tag for one accepted byte and advance the tracker copy
   function automatic rsp_type classify_byte(byte_type b);
      rsp_type r;
      r.byte_value  = b;
      r.frame_end   = 1'b0;
      r.checksum_ok = 1'b0;
      case (phase_q)
         ROLE_CMD1: begin
            r.byte_role = ROLE_CMD1;
            sum_q       = sum_q + sum_type'(b);
            phase_q     = ROLE_LEN;
         end
         ROLE_LEN: begin
            r.byte_role = ROLE_LEN;
            sum_q       = sum_q + sum_type'(b);
            left_q      = b;
            // zero length goes straight to the checksum
            phase_q     = (b == '0) ? ROLE_SUM_HI : ROLE_DATA;
         end
         ROLE_DATA: begin
            r.byte_role = ROLE_DATA;
            sum_q       = sum_q + sum_type'(b);
            left_q      = left_q - 1'b1;
            if (left_q == '0) begin
               phase_q = ROLE_SUM_HI;
            end
         end
         ROLE_SUM_HI: begin
            r.byte_role = ROLE_SUM_HI;
            sum_high_q  = b;
            phase_q     = ROLE_SUM_LO;
         end
         ROLE_SUM_LO: begin
            r.byte_role   = ROLE_SUM_LO;
            r.frame_end   = 1'b1;
            r.checksum_ok = ({sum_high_q, b} == sum_q);
            sum_q         = '0;
            left_q        = '0;
            phase_q       = ROLE_CMD0;
         end
         default: begin
            // first command byte restarts the sum
            r.byte_role = ROLE_CMD0;
            sum_q       = sum_type'(b);
            left_q      = '0;
            phase_q     = ROLE_CMD1;
         end
      endcase
      return r;
   endfunction

   // queue one byte and track where the block will be in its frame
   function automatic void push_rx(byte_type b);
      rx_stream.push_back(b);
      case (gen_role)
         ROLE_CMD0:   gen_role = ROLE_CMD1;
         ROLE_CMD1:   gen_role = ROLE_LEN;
         ROLE_LEN: begin
            gen_left = b;
            gen_role = (b == '0) ? ROLE_SUM_HI : ROLE_DATA;
         end
         ROLE_DATA: begin
            gen_left = gen_left - 1;
            if (gen_left == 0) begin
               gen_role = ROLE_SUM_HI;
            end
         end
         ROLE_SUM_HI: gen_role = ROLE_SUM_LO;
         default:     gen_role = ROLE_CMD0;
      endcase
   endfunction

   // finish whatever frame the block thinks it is in, keeping the length short
   function automatic void realign();
      while (gen_role != ROLE_CMD0) begin
         if (gen_role == ROLE_LEN) begin
            push_rx(byte_type'($urandom_range(0, 3)));
         end else begin
            push_rx(byte_type'($urandom_range(0, 255)));
         end
      end
   endfunction

   // build one frame, optionally with a bad checksum or one byte lost
   function automatic void push_frame(byte_type c0, byte_type c1, byte_type len,
                                      payload_fill_type fill, bit corrupt, int drop);
      byte_type frame[$];
      sum_type  sum;
      byte_type p;
      sum = sum_type'(c0) + sum_type'(c1) + sum_type'(len);
      frame.push_back(c0);
      frame.push_back(c1);
      frame.push_back(len);
      for (int i = 0; i < int'(len); i++) begin
         case (fill)
            FILL_ONES:  p = 8'hFF;
            FILL_ZEROS: p = 8'h00;
            default:    p = byte_type'($urandom_range(0, 255));
         endcase
         frame.push_back(p);
         sum = sum + sum_type'(p);
      end
      if (corrupt) begin
         sum = sum ^ sum_type'($urandom_range(1, 65535));
      end
      frame.push_back(sum[15:8]);
      frame.push_back(sum[7:0]);
      foreach (frame[i]) begin
         if (i != drop) begin
            push_rx(frame[i]);
         end
      end
   endfunction

   task automatic note_failure(string msg);
      fail_count++;
      if (fail_count <= MaxReports) begin
         $display("[%0t] %s", $realtime, msg);
      end
   endtask

   // driver: offers the queued bytes, with a random hold-off before each item
   int unsigned send_gap;
   bit          send_quiet;

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.rx_byte <= '0;
         send_gap       <= 0;
      end else begin
         // item taken at this edge: predict its tag now
         if (req_if.valid && req_if.ready) begin
            expected_tags.push_back(classify_byte(req_if.rx_byte));
            items_in++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (send_gap > 0) begin
               req_if.valid <= 1'b0;
               send_gap     <= send_gap - 1;
            end else if (rx_stream.size() > 0) begin
               req_if.valid   <= 1'b1;
               req_if.rx_byte <= rx_stream.pop_front();
               // every so often switch between gappy and back-to-back stretches
               if ($urandom_range(0, 39) == 0) begin
                  send_quiet = !send_quiet;
               end
               send_gap <= send_quiet ? 0 : $urandom_range(0, MaxWait);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: takes result items, stalling at random after each one
   int unsigned recv_stall;
   bit          recv_quiet;

   always @(posedge clock) begin : monitor
      int unsigned stall;
      rsp_type     got;
      rsp_type     want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         recv_stall   <= 0;
      end else if (rsp_if.valid && rsp_if.ready) begin
         got.byte_value  = rsp_if.byte_value;
         got.byte_role   = rsp_if.byte_role;
         got.frame_end   = rsp_if.frame_end;
         got.checksum_ok = rsp_if.checksum_ok;
         results_seen++;
         if (expected_tags.size() == 0) begin
            note_failure($sformatf("unexpected result: value %02h role %0d end %0b ok %0b",
                                   got.byte_value, got.byte_role, got.frame_end,
                                   got.checksum_ok));
         end else begin
            want = expected_tags.pop_front();
            if (got.byte_value !== want.byte_value || got.byte_role !== want.byte_role ||
                got.frame_end !== want.frame_end || got.checksum_ok !== want.checksum_ok) begin
               note_failure($sformatf({"result %0d mismatch: expected value %02h role %0d ",
                                       "end %0b ok %0b, got value %02h role %0d end %0b ok %0b"},
                                      results_seen, want.byte_value, want.byte_role,
                                      want.frame_end, want.checksum_ok, got.byte_value,
                                      got.byte_role, got.frame_end, got.checksum_ok));
            end
            if (want.frame_end) begin
               if (want.checksum_ok) begin
                  frames_good++;
               end else begin
                  frames_bad++;
               end
            end
         end
         if ($urandom_range(0, 39) == 0) begin
            recv_quiet = !recv_quiet;
         end
         stall = recv_quiet ? 0 : $urandom_range(0, MaxWait);
         rsp_if.ready <= (stall == 0);
         recv_stall   <= stall;
      end else if (recv_stall > 0) begin
         // hold ready low until the drawn stall has run out
         recv_stall   <= recv_stall - 1;
         rsp_if.ready <= (recv_stall == 1);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // stimulus and end of run
   initial begin : stimulus
      bit    long_done;
      int    pick;
      int    len;
      gen_role       = ROLE_CMD0;
      gen_left       = 0;
      long_done      = 1'b0;

      // zero-length frames, command byte extremes, good and bad checksum
      push_frame(8'h00, 8'hFF, 8'd0, FILL_RANDOM, 1'b0, NoDrop);
      push_frame(8'hFF, 8'h00, 8'd0, FILL_RANDOM, 1'b1, NoDrop);
      // short frame with all-ones payload
      push_frame(8'hA5, 8'h5A, 8'd3, FILL_ONES, 1'b0, NoDrop);
      // a stray byte knocks the framing off until the stream realigns
      push_rx(8'h80);
      realign();

      // random part: mostly well-formed frames, some noise and lost bytes
      while (rx_stream.size() < StreamItems) begin
         pick = $urandom_range(0, 99);
         if (!long_done && (pick < 2 || rx_stream.size() > StreamItems / 2)) begin
            // maximum length of all-ones bytes: the sum wraps past 16 bits
            push_frame(8'hFF, 8'hFF, 8'd255, FILL_ONES, 1'b0, NoDrop);
            long_done = 1'b1;
         end else if (pick < 10) begin
            repeat ($urandom_range(1, 6)) push_rx(byte_type'($urandom_range(0, 255)));
            realign();
         end else if (pick < 18) begin
            len = $urandom_range(0, 12);
            push_frame(byte_type'($urandom_range(0, 255)), byte_type'($urandom_range(0, 255)),
                       byte_type'(len), FILL_RANDOM, 1'b0, $urandom_range(0, len + 4));
            realign();
         end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 60) : $urandom_range(0, 15);
            push_frame(byte_type'($urandom_range(0, 255)), byte_type'($urandom_range(0, 255)),
                       byte_type'(len),
                       ($urandom_range(0, 19) == 0) ? FILL_ZEROS : FILL_RANDOM,
                       ($urandom_range(0, 4) == 0), NoDrop);
         end
      end
      if (!long_done) begin
         push_frame(8'hFF, 8'hFF, 8'd255, FILL_ONES, 1'b0, NoDrop);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // all bytes offered and taken, then every tag back
      while (rx_stream.size() != 0 || req_if.valid) @(posedge clock);
      while (expected_tags.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("%0d bytes tagged and checked across %0d closed frames", results_seen,
               frames_good + frames_bad);
      $display("frames closing with a matching checksum: %0d, with a wrong one: %0d",
               frames_good, frames_bad);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // guard against a hung handshake
   initial begin
      #5_000_000;
      $display("timeout with %0d tags still outstanding", expected_tags.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule
